// ===== src/tle_pkg.sv =====
// ----------------------------------------------------------------------------
// tle_pkg: shared types and constants of the telnet line editor
// Byte codes, result kinds, parser phases and the result list type.
// ----------------------------------------------------------------------------
`default_nettype none

package tle_pkg;

  localparam int TLE_LINE_LIMIT = 128;
  localparam logic [6:0] TLE_MAX_LEN_RESET = 7'd99;

  localparam logic [7:0] B_IAC    = 8'hFF;
  localparam logic [7:0] B_DO     = 8'hFD;
  localparam logic [7:0] B_DONT   = 8'hFE;
  localparam logic [7:0] B_ECHO   = 8'h01;
  localparam logic [7:0] B_CR     = 8'h0D;
  localparam logic [7:0] B_LF     = 8'h0A;
  localparam logic [7:0] B_NUL    = 8'h00;
  localparam logic [7:0] B_BS     = 8'h08;
  localparam logic [7:0] B_DEL    = 8'h7F;
  localparam logic [7:0] B_SPACE  = 8'h20;
  localparam logic [7:0] B_TILDE  = 8'h7E;
  localparam logic [7:0] B_PROMPT = 8'h3E;

  localparam logic [1:0] K_SEND   = 2'd0;
  localparam logic [1:0] K_APPEND = 2'd1;
  localparam logic [1:0] K_ERASE  = 2'd2;
  localparam logic [1:0] K_EOL    = 2'd3;

  localparam logic [1:0] PH_TEXT = 2'd0;
  localparam logic [1:0] PH_IAC  = 2'd1;
  localparam logic [1:0] PH_VERB = 2'd2;

  localparam int RES_MAX = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } res_t;

  typedef struct packed {
    logic [2:0]               cnt;
    res_t [RES_MAX-1:0]       ent;
  } res_list_t;

endpackage

`default_nettype wire

// ===== src/tle_decode.sv =====
// ----------------------------------------------------------------------------
// tle_decode: parser state and per-byte result list
// Holds the editor state and the line length register, and builds the list
// of up to four results for the item being accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_decode #(
  parameter int LINE_LIMIT = tle_pkg::TLE_LINE_LIMIT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [6:0]          cfg_max_line_length,
  input  wire logic                in_take,
  input  wire logic [7:0]          in_rx_byte,
  input  wire logic                in_new_connection,
  output tle_pkg::res_list_t       res_list
);
  import tle_pkg::*;

  localparam int CAP_MAX = (LINE_LIMIT - 1 < 127) ? LINE_LIMIT - 1 : 127;

  logic [6:0] max_len_r;
  logic       echo_on_r, echo_on_nxt;
  logic [6:0] line_count_r, line_count_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] verb_r, verb_nxt;
  logic       after_cr_r, after_cr_nxt;

  logic [6:0] cap;
  logic       skip;
  logic       printable;
  res_list_t  lst;

  always_comb begin
    cap = max_len_r;
    if (cap == 7'd0) cap = 7'd1;
    if (cap > 7'(CAP_MAX)) cap = 7'(CAP_MAX);
  end

  assign printable = (in_rx_byte >= B_SPACE) && (in_rx_byte <= B_TILDE);

  always_comb begin
    echo_on_nxt    = echo_on_r;
    line_count_nxt = line_count_r;
    phase_nxt      = phase_r;
    verb_nxt       = verb_r;
    after_cr_nxt   = after_cr_r;
    skip           = 1'b0;
    lst            = '0;
    if (in_new_connection) begin
      echo_on_nxt    = 1'b1;
      line_count_nxt = 7'd0;
      phase_nxt      = PH_TEXT;
      verb_nxt       = 8'd0;
      after_cr_nxt   = 1'b0;
    end else begin
      unique case (phase_r)
        PH_TEXT: begin
          if (after_cr_r) begin
            after_cr_nxt = 1'b0;
            skip = (in_rx_byte == B_LF) || (in_rx_byte == B_NUL);
          end
          if (!skip) begin
            if (line_count_r >= cap || in_rx_byte == B_CR) begin
              if (echo_on_r) begin
                lst.ent[0] = '{K_SEND, B_CR};
                lst.ent[1] = '{K_SEND, B_LF};
                lst.ent[2] = '{K_EOL, 8'd0};
                lst.ent[3] = '{K_SEND, B_PROMPT};
                lst.cnt    = 3'd4;
              end else begin
                lst.ent[0] = '{K_EOL, 8'd0};
                lst.ent[1] = '{K_SEND, B_PROMPT};
                lst.cnt    = 3'd2;
              end
              line_count_nxt = 7'd0;
              after_cr_nxt   = 1'b1;
            end else if (in_rx_byte == B_IAC) begin
              phase_nxt = PH_IAC;
            end else if (in_rx_byte == B_BS || in_rx_byte == B_DEL) begin
              if (line_count_r != 7'd0) begin
                if (echo_on_r) begin
                  lst.ent[0] = '{K_SEND, B_BS};
                  lst.ent[1] = '{K_SEND, B_SPACE};
                  lst.ent[2] = '{K_SEND, B_BS};
                  lst.ent[3] = '{K_ERASE, 8'd0};
                  lst.cnt    = 3'd4;
                end else begin
                  lst.ent[0] = '{K_ERASE, 8'd0};
                  lst.cnt    = 3'd1;
                end
                line_count_nxt = line_count_r - 7'd1;
              end
            end else if (printable) begin
              lst.ent[0] = '{K_APPEND, in_rx_byte};
              lst.ent[1] = '{K_SEND, in_rx_byte};
              lst.cnt    = echo_on_r ? 3'd2 : 3'd1;
              line_count_nxt = line_count_r + 7'd1;
            end
          end
        end
        PH_IAC: begin
          verb_nxt  = in_rx_byte;
          phase_nxt = PH_VERB;
        end
        default: begin
          if (in_rx_byte == B_ECHO) begin
            if (verb_r == B_DO) echo_on_nxt = 1'b1;
            else if (verb_r == B_DONT) echo_on_nxt = 1'b0;
          end
          phase_nxt = PH_TEXT;
        end
      endcase
    end
  end

  assign res_list = lst;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r    <= TLE_MAX_LEN_RESET;
      echo_on_r    <= 1'b1;
      line_count_r <= 7'd0;
      phase_r      <= PH_TEXT;
      verb_r       <= 8'd0;
      after_cr_r   <= 1'b0;
    end else begin
      if (cfg_we) max_len_r <= cfg_max_line_length;
      if (in_take) begin
        echo_on_r    <= echo_on_nxt;
        line_count_r <= line_count_nxt;
        phase_r      <= phase_nxt;
        verb_r       <= verb_nxt;
        after_cr_r   <= after_cr_nxt;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("parser phase out of range");
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    line_count_r <= 7'(CAP_MAX))
    else $error("line count above limit");
  a_eol_marks_cr: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && !in_new_connection && phase_r == PH_TEXT
      && (lst.ent[0].kind == K_EOL || lst.ent[2].kind == K_EOL)
      |=> after_cr_r && line_count_r == 7'd0)
    else $error("end of line did not reset line state");
`endif

endmodule

`default_nettype wire

// ===== src/tle_resbuf.sv =====
// ----------------------------------------------------------------------------
// tle_resbuf: result buffer
// Loads the result list of one item and hands it out one entry per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_resbuf (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  tle_pkg::res_list_t       res_list,
  output logic                     free,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_kind,
  output logic [7:0]               out_data,
  output logic                     out_last
);
  import tle_pkg::*;

  res_t [RES_MAX-1:0] ent_r;
  logic [2:0]         cnt_r;
  logic [1:0]         idx_r;
  logic               pop;

  assign out_valid = (cnt_r != 3'd0);
  assign out_last  = ({1'b0, idx_r} == cnt_r - 3'd1);
  assign out_kind  = ent_r[idx_r].kind;
  assign out_data  = ent_r[idx_r].data;
  assign pop       = out_valid && out_ready;
  assign free      = !out_valid || (pop && out_last);

  always_ff @(posedge clk) begin
    if (load) ent_r <= res_list.ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      idx_r <= 2'd0;
    end else if (load) begin
      cnt_r <= res_list.cnt;
      idx_r <= 2'd0;
    end else if (pop) begin
      if (out_last) begin
        cnt_r <= 3'd0;
        idx_r <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, idx_r} < cnt_r))
    else $error("result index past list end");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(RES_MAX))
    else $error("result count out of range");
  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !out_last |=> out_valid && idx_r == $past(idx_r) + 2'd1)
    else $error("result list cut short");
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    pop && out_last && !load |=> !out_valid)
    else $error("result after final entry");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("result list overwritten");
`endif

endmodule

`default_nettype wire

// ===== src/telnet_line_editor.sv =====
// ----------------------------------------------------------------------------
// telnet_line_editor: telnet NVT line editor
// Parses received telnet bytes, edits the input line and emits echo and prompt bytes,
// line edits and end-of-line marks as result items.
//
//   channel | direction | payload
//   in_     | input     | rx_byte, new_connection
//   out_    | output    | kind, data, last
//   cfg_    | input     | max_line_length
//
// An item is decoded in the cycle it is accepted; its 0 to 4 results leave
// the result buffer one per cycle while out_ready is high, starting the next cycle.
// The result buffer's single output port paces the input: a new byte waits
// until the final result of the previous byte is taken.
// in_ready is high while the buffer is empty or its final result is taken.
// Synchronous active-low reset; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module telnet_line_editor #(
  parameter int LINE_LIMIT = tle_pkg::TLE_LINE_LIMIT
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_new_connection,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_data,
  output logic            out_last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [6:0] cfg_max_line_length
);
  import tle_pkg::*;

  res_list_t res_list;
  logic      free;
  logic      take;

  assign cfg_ready = 1'b1;
  assign in_ready  = free;
  assign take      = in_valid && free;

  tle_decode #(
    .LINE_LIMIT(LINE_LIMIT)
  ) u_decode (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_max_line_length (cfg_max_line_length),
    .in_take             (take),
    .in_rx_byte          (in_rx_byte),
    .in_new_connection   (in_new_connection),
    .res_list            (res_list)
  );

  tle_resbuf u_resbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .res_list  (res_list),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_data  (out_data),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire
